>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the block average design.
// Included by the top level, which checks its own control logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define CHK_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, checked outside reset.
`define CHK_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CHK_IMP(lbl, clk, rst_n, ante, cons)
`define CHK_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/mcdba_pkg.sv
// Package of the block average design: fixed field widths, constants and shared types.
// Has no dependencies; the interfaces, the divider and the top level import it.
package mcdba_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int CHAN_W    = 2;
	localparam int WIN_W     = 11;
	localparam int AVG_W     = 16;
	localparam int FRAC_BITS = 4;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 11'd8;

	// Handshake-free status of the iterative divider.
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

>>> rtl/mcdba_if.sv
// Channel interfaces of the block average design: samples, results and configuration.
// Depends on mcdba_pkg for the field widths.
interface mcdba_smp_if import mcdba_pkg::*;;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic [CHAN_W-1:0]   channel;

	modport source (output valid, output sample, output channel, input ready);
	modport sink (input valid, input sample, input channel, output ready);
endinterface

interface mcdba_res_if import mcdba_pkg::*;;
	logic             valid;
	logic             ready;
	logic [AVG_W-1:0] average_q4;
	logic             refreshed;

	modport source (output valid, output average_q4, output refreshed, input ready);
	modport sink (input valid, input average_q4, input refreshed, output ready);
endinterface

interface mcdba_cfg_if import mcdba_pkg::*;;
	logic             valid;
	logic             ready;
	logic [WIN_W-1:0] window_length;

	modport source (output valid, output window_length, input ready);
	modport sink (input valid, input window_length, output ready);
endinterface

>>> rtl/mcdba_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No package dependencies.
module mcdba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/mcdba_div.sv
// Restoring radix-2 divider, one quotient bit per cycle, saturating to the average width.
// Depends on mcdba_pkg for the result width and the status struct.
module mcdba_div import mcdba_pkg::*; #(
	parameter int NUM_W = 27,
	parameter int DEN_W = 11
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] dividend,
	input  logic [DEN_W-1:0] divisor,
	output logic [AVG_W-1:0] quotient,
	output div_stat_t        stat
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   rem_sub;
	logic             ge;
	logic [DEN_W-1:0] rem_nxt;

	// The shifted partial remainder stays below twice the divisor, so one
	// compare and subtract settles each quotient bit.
	always_comb begin
		rem_sh  = {rem_q, num_q[NUM_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
		rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend register shifts out its top bit and collects quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= rem_nxt;
		end
	end

	assign quotient = (|num_q[NUM_W-1:AVG_W]) ? '1 : num_q[AVG_W-1:0];
	assign stat     = '{busy: busy_q, done: done_q};

endmodule

>>> rtl/multichannel_diff_block_average.sv
// Top level of the multichannel block average of absolute differences.
// Depends on mcdba_pkg, the channel interfaces, mcdba_ram, mcdba_div and assert_macros.svh.
//
// Usage: each item on the samples channel carries one ADC reading and a channel
// number. Per channel the block accumulates the absolute difference to that
// channel's previous reading; after window_length readings the channel's held
// average becomes sum*16/window (4 fractional bits, truncated) and the sum and
// count restart. Every accepted item yields exactly one result item with the
// channel's held average and a refreshed flag. Items for a channel number at or
// above CHANNELS change nothing and return zero on both fields.
// Timing: one item at a time. An item that does not close a window passes through
// the memory read, the update and write back, and the result load; one that does
// also runs the restoring divider, one quotient bit per cycle over SAMPLE_BITS+15
// bits, before its result is loaded.
// The state of all channels lives in one RAM with a registered read;
// valid bits in flip-flops make never-written entries read as zero, and a
// write to window_length drops only the sum and count valid bits.
// Reset: the window length returns to 8 and every channel reads as zero.
// A stalled result stays in the output register; the block takes no new item
// until that result has been loaded. The configuration port is always ready;
// the user must write it only while the block is idle; the block does not enforce this.
module multichannel_diff_block_average import mcdba_pkg::*; #(
	parameter int CHANNELS    = 4,
	parameter int SAMPLE_BITS = 12,
	parameter int MAX_WINDOW  = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	mcdba_smp_if.sink   samples,
	mcdba_res_if.source results,
	mcdba_cfg_if.sink   cfg
);

`include "assert_macros.svh"

	localparam int SMP_W  = SAMPLE_BITS;
	localparam int SUM_W  = SAMPLE_BITS + WIN_W;
	localparam int NUM_W  = SUM_W + FRAC_BITS;
	localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	// One RAM entry holds the whole state of a channel.
	typedef struct packed {
		logic [SMP_W-1:0] prev;
		logic [SUM_W-1:0] sum;
		logic [WIN_W-1:0] cnt;
		logic [AVG_W-1:0] held;
	} ent_t;

	logic [1:0]          state_q;
	logic [WIN_W-1:0]    win_q;
	logic [CHANNELS-1:0] ent_vld_q;
	logic [CHANNELS-1:0] win_vld_q;
	logic [SMP_W-1:0]    smp_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                ok_q;
	logic [AVG_W-1:0]    res_avg_q;
	logic                res_ref_q;
	logic                out_vld_q;
	logic [AVG_W-1:0]    out_avg_q;
	logic                out_ref_q;

	logic                in_acc;
	logic                out_load;
	logic [SMP_W-1:0]    smp_in;
	logic [ADDR_W-1:0]   addr_in;
	logic                ok_in;
	logic [WIN_W-1:0]    eff_win;

	ent_t                rd_ent;
	ent_t                wr_ent;
	logic                mem_we;
	logic [SMP_W-1:0]    prev_old;
	logic [AVG_W-1:0]    held_old;
	logic [SUM_W-1:0]    sum_old;
	logic [WIN_W-1:0]    cnt_old;
	logic [SMP_W-1:0]    diff;
	logic [SUM_W-1:0]    sum_new;
	logic [WIN_W-1:0]    cnt_new;
	logic                full;
	logic                div_start;
	logic [AVG_W-1:0]    div_q;
	div_stat_t           div_stat;

	logic [SMP_W+SAMPLE_W-1:0] smp_ext;
	logic [ADDR_W+CHAN_W-1:0]  addr_ext;

	// Only the low SAMPLE_BITS bits of a reading take part.
	assign smp_ext  = {{SMP_W{1'b0}}, samples.sample};
	assign smp_in   = smp_ext[SMP_W-1:0];
	assign addr_ext = {{ADDR_W{1'b0}}, samples.channel};
	assign addr_in  = addr_ext[ADDR_W-1:0];
	assign ok_in    = int'(samples.channel) < CHANNELS;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign cfg.ready     = 1'b1;

	// A window of zero acts as one; the effective window saturates at MAX_WINDOW.
	always_comb begin
		if (win_q == '0) begin
			eff_win = WIN_W'(1);
		end else if (int'(win_q) > MAX_WINDOW) begin
			eff_win = WIN_W'(MAX_WINDOW);
		end else begin
			eff_win = win_q;
		end
	end

	mcdba_ram #(
		.WIDTH ($bits(ent_t)),
		.DEPTH (CHANNELS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (addr_q),
		.wdata (wr_ent),
		.re    (in_acc && ok_in),
		.raddr (addr_in),
		.rdata (rd_ent)
	);

	// Entries that were never written since reset, or whose window was
	// dropped by a configuration write, read as zero.
	always_comb begin
		prev_old = ent_vld_q[addr_q] ? rd_ent.prev : '0;
		held_old = ent_vld_q[addr_q] ? rd_ent.held : '0;
		sum_old  = win_vld_q[addr_q] ? rd_ent.sum : '0;
		cnt_old  = win_vld_q[addr_q] ? rd_ent.cnt : '0;
		diff     = (smp_q >= prev_old) ? smp_q - prev_old : prev_old - smp_q;
		sum_new  = sum_old + SUM_W'(diff);
		cnt_new  = cnt_old + 1'b1;
		full     = cnt_new >= eff_win;
	end

	always_comb begin
		mem_we    = 1'b0;
		div_start = 1'b0;
		wr_ent    = '{prev: smp_q, sum: sum_new, cnt: cnt_new, held: held_old};
		if (state_q == ST_READ && ok_q) begin
			if (full) begin
				div_start = 1'b1;
			end else begin
				mem_we = 1'b1;
			end
		end else if (state_q == ST_DIV && div_stat.done) begin
			mem_we = 1'b1;
			wr_ent = '{prev: smp_q, sum: '0, cnt: '0, held: div_q};
		end
	end

	mcdba_div #(
		.NUM_W (NUM_W),
		.DEN_W (WIN_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_new, {FRAC_BITS{1'b0}}}),
		.divisor  (eff_win),
		.quotient (div_q),
		.stat     (div_stat)
	);

	assign out_load = (state_q == ST_EMIT) && (!out_vld_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			win_q     <= WINDOW_RESET;
			ent_vld_q <= '0;
			win_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				win_q     <= cfg.window_length;
				win_vld_q <= '0;
			end
			if (mem_we) begin
				ent_vld_q[addr_q] <= 1'b1;
				win_vld_q[addr_q] <= 1'b1;
			end
			out_vld_q <= out_load || (out_vld_q && !results.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= div_start ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Item payload and the pending result; these need no reset.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			smp_q  <= smp_in;
			addr_q <= addr_in;
			ok_q   <= ok_in;
		end
		if (state_q == ST_READ) begin
			res_avg_q <= ok_q ? held_old : '0;
			res_ref_q <= 1'b0;
		end else if (state_q == ST_DIV && div_stat.done) begin
			res_avg_q <= div_q;
			res_ref_q <= 1'b1;
		end
		if (out_load) begin
			out_avg_q <= res_avg_q;
			out_ref_q <= res_ref_q;
		end
	end

	assign results.valid      = out_vld_q;
	assign results.average_q4 = out_avg_q;
	assign results.refreshed  = out_ref_q;

	`CHK_IMP(a_div_only_in_div, clk, arst_n, div_stat.busy, state_q == ST_DIV)
	`CHK_IMP(a_we_only_working, clk, arst_n, mem_we, state_q == ST_READ || state_q == ST_DIV)
	`CHK_NXT(a_div_done_emits, clk, arst_n, state_q == ST_DIV && div_stat.done, state_q == ST_EMIT && res_ref_q)

endmodule

>>> dv/tb_top.sv
// Self-checking testbench of multichannel_diff_block_average.
// Depends on mcdba_pkg, the channel interfaces in mcdba_if.sv and the block's RTL.
// A scoreboard class predicts each result item from the accepted sample items.
module tb_top;
	import mcdba_pkg::*;

	localparam int NUM_CH  = 4;
	localparam int MAX_WIN = 1024;

	// Scoreboard: a copy of the per-channel state and the results still due.
	class diff_average_board;
		typedef struct packed {
			logic [AVG_W-1:0] average_q4;
			logic             refreshed;
		} avg_result_t;

		logic [WIN_W-1:0]    window;
		logic [SAMPLE_W-1:0] last_sample [NUM_CH];
		logic [21:0]         diff_sum [NUM_CH];
		logic [WIN_W-1:0]    sample_count [NUM_CH];
		logic [AVG_W-1:0]    held_average [NUM_CH];
		avg_result_t         expected_averages [$];
		int                  mismatch_count;

		function new();
			window = WINDOW_RESET;
			mismatch_count = 0;
			for (int c = 0; c < NUM_CH; c++) begin
				last_sample[c] = '0;
				held_average[c] = '0;
				diff_sum[c] = '0;
				sample_count[c] = '0;
			end
		endfunction

		// A window write restarts every window but keeps samples and averages.
		function void set_window(logic [WIN_W-1:0] w);
			window = w;
			for (int c = 0; c < NUM_CH; c++) begin
				diff_sum[c] = '0;
				sample_count[c] = '0;
			end
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] s, logic [CHAN_W-1:0] c);
			logic [SAMPLE_W-1:0] delta;
			logic [WIN_W-1:0]    span;
			logic [31:0]         quotient;
			avg_result_t         r;
			delta = (s >= last_sample[c]) ? s - last_sample[c] : last_sample[c] - s;
			last_sample[c] = s;
			diff_sum[c] += delta;
			sample_count[c] += 1'b1;
			// A zero window acts as one sample, anything above the maximum as the maximum.
			span = (window == '0) ? WIN_W'(1) : ((window > MAX_WIN) ? WIN_W'(MAX_WIN) : window);
			r.refreshed = 1'b0;
			if (sample_count[c] >= span) begin
				quotient = (32'(diff_sum[c]) << FRAC_BITS) / 32'(span);
				held_average[c] = (quotient > 32'hFFFF) ? 16'hFFFF : quotient[15:0];
				diff_sum[c] = '0;
				sample_count[c] = '0;
				r.refreshed = 1'b1;
			end
			r.average_q4 = held_average[c];
			expected_averages.push_back(r);
		endfunction

		function void flag(string what, avg_result_t want, avg_result_t got);
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%s: expected average_q4=%0d refreshed=%0d, got average_q4=%0d refreshed=%0d",
					what, want.average_q4, want.refreshed, got.average_q4, got.refreshed);
		endfunction

		function void check_result(logic [AVG_W-1:0] avg, logic refr);
			avg_result_t want;
			avg_result_t got;
			got.average_q4 = avg;
			got.refreshed = refr;
			if (expected_averages.size() == 0) begin
				flag("result item with nothing expected", '0, got);
			end else begin
				want = expected_averages.pop_front();
				if (want.average_q4 !== got.average_q4 || want.refreshed !== got.refreshed)
					flag("result mismatch", want, got);
			end
		endfunction

		function void close_out();
			if (expected_averages.size() != 0) begin
				mismatch_count += expected_averages.size();
				$display("%0d result items never arrived", expected_averages.size());
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   steady = 1'b0;   // when set, neither side idles

	diff_average_board board;

	mcdba_smp_if smp_bus();
	mcdba_res_if res_bus();
	mcdba_cfg_if cfg_bus();

	multichannel_diff_block_average i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (smp_bus),
		.results (res_bus),
		.cfg     (cfg_bus)
	);

	always #5 clk = ~clk;

	// Sends one sample item. Random idle cycles come first, with valid low; valid is
	// otherwise left high after acceptance, so back-to-back items keep it asserted
	// and it is never lowered and raised within one time step.
	task automatic send_item(input logic [SAMPLE_W-1:0] s, input logic [CHAN_W-1:0] c);
		while (!steady && $urandom_range(99) < 8) begin
			smp_bus.valid <= 1'b0;
			@(posedge clk);
		end
		smp_bus.valid <= 1'b1;
		smp_bus.sample <= s;
		smp_bus.channel <= c;
		@(posedge clk);
		while (!smp_bus.ready) @(posedge clk);
		board.note_sample(s, c);
	endtask

	// Holds the sender back until every expected result item has come out.
	// It always waits on the clock before returning, so the next item cannot raise valid
	// in the same step in which it was lowered here.
	task automatic wait_for_results();
		smp_bus.valid <= 1'b0;
		do @(posedge clk); while (board.expected_averages.size() != 0);
	endtask

	// Full drain before a register write or the end of the run. Every item yields a
	// result, so an empty queue means the block is idle.
	task automatic drain_results();
		wait_for_results();
		repeat (8) @(posedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] w);
		cfg_bus.valid <= 1'b1;
		cfg_bus.window_length <= w;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		cfg_bus.valid <= 1'b0;
		board.set_window(w);
	endtask

	// Samples are mostly small steps from the channel's last reading, with rail
	// values and fully random readings mixed in.
	function automatic logic [SAMPLE_W-1:0] pick_sample(logic [SAMPLE_W-1:0] prev);
		int unsigned k;
		int          v;
		k = $urandom_range(9);
		if (k == 0)
			return '0;
		if (k == 1)
			return '1;
		if (k <= 4)
			return SAMPLE_W'($urandom_range(4095));
		v = int'(prev) + int'($urandom_range(80)) - 40;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return SAMPLE_W'(v);
	endfunction

	// One random phase at a fixed window. With focus set, nearly every item goes to
	// channel 0 so that a long window actually closes. Somewhere in the middle the
	// sender waits for the block to empty completely.
	task automatic run_phase(input logic [WIN_W-1:0] w, input int n, input bit focus);
		logic [CHAN_W-1:0] c;
		drain_results();
		write_window(w);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2 || $urandom_range(199) == 0)
				wait_for_results();
			if (focus)
				c = (i % 32 == 31) ? CHAN_W'($urandom_range(3)) : '0;
			else
				c = CHAN_W'($urandom_range(3));
			send_item(pick_sample(board.last_sample[c]), c);
		end
	endtask

	// Result side: every accepted result item is checked against the oldest
	// prediction. Ready is dropped at random, with about 8 percent probability at each
	// clock edge, unless the current stretch runs without idling.
	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res_bus.valid && res_bus.ready)
				board.check_result(res_bus.average_q4, res_bus.refreshed);
			res_bus.ready <= arst_n && (steady || $urandom_range(99) >= 8);
		end
	end

	// Stimulus.
	initial begin
		board = new();
		arst_n = 1'b0;
		smp_bus.valid = 1'b0;
		smp_bus.sample = '0;
		smp_bus.channel = '0;
		cfg_bus.valid = 1'b0;
		cfg_bus.window_length = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset window of 8. Channel 0 alternates between the
		// rails; its first item differs from the zero previous sample after reset, so
		// the window closes at the largest possible average. Channel 1 stays flat at
		// zero and closes with a zero average. Channels 2 and 3 leave partial windows
		// that the next register write must throw away.
		for (int i = 0; i < 8; i++) begin
			send_item((i % 2 == 0) ? SAMPLE_W'(4095) : SAMPLE_W'(0), CHAN_W'(0));
			send_item('0, CHAN_W'(1));
		end
		send_item(SAMPLE_W'(2048), CHAN_W'(2));
		send_item(SAMPLE_W'(4094), CHAN_W'(3));

		// A zero window behaves as a window of one: every item refreshes, and the
		// previous samples survive the write.
		drain_results();
		write_window('0);
		send_item('0, CHAN_W'(2));
		send_item(SAMPLE_W'(4095), CHAN_W'(3));
		send_item(SAMPLE_W'(4095), CHAN_W'(3));
		send_item(SAMPLE_W'(4095), CHAN_W'(0));

		// Random part. The all-ones window saturates to the maximum, so a focused run
		// on channel 0 must not refresh before that many samples have been collected.
		run_phase(WIN_W'(1), 60, 1'b0);
		run_phase(WIN_W'(2047), 150, 1'b1);
		steady = 1'b1;
		run_phase(WIN_W'(MAX_WIN), 40, 1'b0);
		run_phase(WIN_W'(3), 60, 1'b0);
		steady = 1'b0;
		run_phase(WIN_W'(2), 50, 1'b0);
		run_phase(WIN_W'(5), 50, 1'b0);
		run_phase(WIN_W'(16), 60, 1'b1);
		for (int p = 0; p < 4; p++)
			run_phase(WIN_W'($urandom_range(1, 12)), 15, 1'b0);

		drain_results();
		board.close_out();
		if (board.mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("simulation failed");
		$finish;
	end

endmodule
